@@ src/lis_pkg.sv @@
// Shared types and constants for the longest increasing subsequence block.
package lis_pkg;

   localparam int MAX_LEN_DEF    = 1024;
   localparam int VALUE_BITS_DEF = 32;
   localparam int LEN_BITS       = 11;
   localparam int RSP_DATA_BITS  = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_LAST,
      ST_CHECK_LAST,
      ST_PROBE,
      ST_COMPARE,
      ST_FINISH
   } lis_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_in;
      logic rd_last;
      logic append;
      logic set_ovf;
      logic search_init;
      logic rd_mid;
      logic step;
      logic wr_pos;
      logic finish;
   } lis_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero;
      logic full;
      logic tail_less;
      logic search_done;
      logic is_last;
      logic out_free;
   } lis_status_type;

endpackage

@@ src/lis_ram.sv @@
// Generic single-port RAM with registered read data.
module lis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/lis_ctrl.sv @@
// Sequencing state machine for tail lookup, binary search and result hand-off.
module lis_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  lis_pkg::lis_status_type status,
   output lis_pkg::lis_cmd_type    cmd
);
   import lis_pkg::*;

   lis_state_type state_ff;
   lis_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_READ_LAST;
            end
         end
         ST_READ_LAST: begin
            if (status.count_zero) begin
               cmd.append = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.rd_last = 1'b1;
               state_in    = ST_CHECK_LAST;
            end
         end
         ST_CHECK_LAST: begin
            if (status.tail_less) begin
               if (status.full) begin
                  cmd.set_ovf = 1'b1;
               end else begin
                  cmd.append = 1'b1;
               end
               state_in = ST_FINISH;
            end else begin
               cmd.search_init = 1'b1;
               state_in        = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (status.search_done) begin
               cmd.wr_pos = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.rd_mid = 1'b1;
               state_in   = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.step = 1'b1;
            state_in = ST_PROBE;
         end
         ST_FINISH: begin
            if (!status.is_last) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/lis_dpath.sv @@
// Tail memory, search bounds, set counters and the result register.
module lis_dpath #(
   parameter int MAX_LEN    = lis_pkg::MAX_LEN_DEF,
   parameter int VALUE_BITS = lis_pkg::VALUE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [VALUE_BITS-1:0]               in_value,
   input  logic                                in_last,
   input  lis_pkg::lis_cmd_type                cmd,
   output lis_pkg::lis_status_type             status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lis_pkg::LEN_BITS-1:0]        rsp_len,
   output logic                                rsp_ovf
);
   import lis_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_LEN);
   localparam int CNT_BITS = $clog2(MAX_LEN + 1);

   logic [VALUE_BITS-1:0] key_ff;
   logic                  last_ff;
   logic [CNT_BITS-1:0]   count_ff;
   logic                  ovf_ff;
   logic [IDX_BITS-1:0]   lo_ff;
   logic [IDX_BITS-1:0]   hi_ff;
   logic                  rsp_valid_ff;
   logic [LEN_BITS-1:0]   rsp_len_ff;
   logic                  rsp_ovf_ff;

   logic [IDX_BITS-1:0]   mid;
   logic [IDX_BITS-1:0]   ram_addr;
   logic [CNT_BITS-1:0]   count_less_one;
   logic                  ram_we;
   logic [VALUE_BITS-1:0] ram_rd_data;
   logic                  tail_less;

   // Offset-binary key: flipping the sign bit lets an unsigned compare order signed values.
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         key_ff <= {~in_value[VALUE_BITS-1], in_value[VALUE_BITS-2:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
      end else if (cmd.load_in) begin
         last_ff <= in_last;
      end
   end

   assign mid            = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign count_less_one = count_ff - CNT_BITS'(1);
   assign tail_less      = ram_rd_data < key_ff;

   always_comb begin
      ram_addr = lo_ff;
      if (cmd.rd_last) begin
         ram_addr = count_less_one[IDX_BITS-1:0];
      end else if (cmd.append) begin
         ram_addr = count_ff[IDX_BITS-1:0];
      end else if (cmd.rd_mid) begin
         ram_addr = mid;
      end
   end

   assign ram_we = cmd.append | cmd.wr_pos;

   lis_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_LEN)
   ) u_tails (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (key_ff),
      .rd_data (ram_rd_data)
   );

   // The last tail is known not to be below the key, so the search runs over all but it.
   always_ff @(posedge clock) begin
      if (cmd.search_init) begin
         lo_ff <= '0;
         hi_ff <= count_less_one[IDX_BITS-1:0];
      end else if (cmd.step) begin
         if (tail_less) begin
            lo_ff <= mid + IDX_BITS'(1);
         end else begin
            hi_ff <= mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.finish) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         if (cmd.append) begin
            count_ff <= count_ff + CNT_BITS'(1);
         end
         if (cmd.set_ovf) begin
            ovf_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_len_ff <= LEN_BITS'(count_ff);
         rsp_ovf_ff <= ovf_ff;
      end
   end

   assign status.count_zero  = count_ff == '0;
   assign status.full        = count_ff == CNT_BITS'(MAX_LEN);
   assign status.tail_less   = tail_less;
   assign status.search_done = lo_ff == hi_ff;
   assign status.is_last     = last_ff;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_len   = rsp_len_ff;
   assign rsp_ovf   = rsp_ovf_ff;

endmodule

@@ src/lis_length_patience.sv @@
// Top level of the longest strictly increasing subsequence length block.
// This block takes a stream of signed values, grouped into sets by tlast, and returns one
// transfer per set holding the length of the longest strictly increasing subsequence of that
// set, along with a flag that says the tail memory ran out of room. It keeps the smallest
// possible tail of every subsequence length in a sorted single-port RAM of MAX_LEN entries.
// A value above the largest tail is appended; otherwise it overwrites the first tail that is
// not below it, which a binary search finds. One item is processed at a time. An append
// follows a look at the last tail, except for the first item of a set, which needs no
// look at the last tail. An item that needs the search runs a series of probes, and a set
// holding n tails needs up to ceil(log2(n)) probes. Each probe issues a read in one state
// and compares in the next, as the RAM's read port is registered. When the final item of a
// set finds an earlier result still waiting in the output register, it holds until that
// transfer completes; an item that is not last never waits on the output side. If an append
// finds the memory full, the length stays at MAX_LEN and the overflow flag is set for the
// rest of the set. The length field is 11 bits wide and wraps above 2047. No clearing pass is
// needed after reset: only entries below the current tail count are ever read.
module lis_length_patience #(
   parameter int MAX_LEN    = lis_pkg::MAX_LEN_DEF,
   parameter int VALUE_BITS = lis_pkg::VALUE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // value in [VALUE_BITS-1:0], zero padding above
   input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] req_tdata,
   // last_of_set
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // lis_length in [10:0], overflowed in [11], zero padding above
   output logic [lis_pkg::RSP_DATA_BITS-1:0]     rsp_tdata
);
   import lis_pkg::*;

   localparam int PAD_BITS = RSP_DATA_BITS - LEN_BITS - 1;

   lis_cmd_type         cmd;
   lis_status_type      status;
   logic [LEN_BITS-1:0] rsp_len;
   logic                rsp_ovf;

   // The controller only sequences; every stored value lives in the datapath.
   lis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lis_dpath #(
      .MAX_LEN    (MAX_LEN),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .in_value  (req_tdata[VALUE_BITS-1:0]),
      .in_last   (req_tlast),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_len   (rsp_len),
      .rsp_ovf   (rsp_ovf)
   );

   // Pack the result fields from the lowest bit up and fill to a whole number of bytes.
   assign rsp_tdata = {{PAD_BITS{1'b0}}, rsp_ovf, rsp_len};

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the longest increasing subsequence length block.
`timescale 1ns / 1ps

// The run feeds sets of signed values into the block and checks one length transfer per set.
// An initial block fills a queue of pending values first. A short directed part covers the
// field extremes, equal values, falling and rising runs, and a set that fills the tail memory
// exactly and then runs past it. After that come random sets of mixed shapes. A clocked
// driver offers the values with random gaps. Every value it hands over goes through a
// patience-sort tracker that keeps its own sorted tail array, so the expected length and
// overflow flag are known when the last value of a set is accepted. A clocked monitor takes
// the results with random stalls. Once in the run it holds off for a long stretch so that
// the block backs up and stalls its input. The monitor compares each result with the oldest
// expected one. A watchdog ends the run if no transfer happens on either side for too long.
module testbench;
   import lis_pkg::*;

   localparam int VALUE_W      = VALUE_BITS_DEF;
   localparam int CAPACITY     = MAX_LEN_DEF;
   localparam int RANDOM_ITEMS = 300;
   localparam int IDLE_LIMIT   = 4000;
   localparam int LONG_HOLD    = 600;
   localparam int HOLD_AT      = 12;
   localparam int DRAIN_CYCLES = 64;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               last;
   } set_value_type;

   typedef struct {
      logic [LEN_BITS-1:0] lis_length;
      logic                overflowed;
   } set_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // value in [31:0]
   logic [VALUE_W-1:0]       req_tdata  = '0;
   // last_of_set
   logic                     req_tlast  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // lis_length in [10:0], overflowed in [11], zero padding above
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   lis_length_patience #(
      .MAX_LEN   (CAPACITY),
      .VALUE_BITS(VALUE_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Values waiting to be offered, and results that accepted sets still owe.
   set_value_type  pending_values[$];
   set_result_type expected_lengths[$];

   // The tracker's own copy of the block's state: sorted tails, their count and the
   // overflow mark of the current set.
   logic signed [VALUE_W-1:0] tail_mem [0:CAPACITY-1];
   int unsigned               tail_total = 0;
   bit                        ovf_seen   = 1'b0;

   int queued_values   = 0;
   int queued_sets     = 0;
   int accepted_values = 0;
   int lengths_checked = 0;
   int overflow_sets   = 0;
   int mismatch_count  = 0;
   int idle_cycles     = 0;

   int  send_pause  = 0;
   bit  send_calm   = 1'b0;
   int  stall_left  = 0;
   bit  recv_calm   = 1'b0;
   int  hold_left   = 0;
   bit  hold_done   = 1'b0;

   // Patience sorting step for one accepted value. A value above the largest tail extends
   // the longest run; otherwise it lowers the first tail that is not below it. On the last
   // value of a set the length and overflow mark become an expected result and are cleared.
   function void absorb_value(logic signed [VALUE_W-1:0] v, logic last_flag);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      set_result_type r;
      if (tail_total == 0 || tail_mem[tail_total-1] < v) begin
         if (tail_total < CAPACITY) begin
            tail_mem[tail_total] = v;
            tail_total++;
         end else begin
            // No room left: the length saturates and the set is marked.
            ovf_seen = 1'b1;
         end
      end else begin
         lo = 0;
         hi = tail_total;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (tail_mem[mid] < v) lo = mid + 1;
            else hi = mid;
         end
         // An equal value lands on its twin, so strictness never grows the count.
         tail_mem[lo] = v;
      end
      if (last_flag) begin
         r.lis_length = tail_total[LEN_BITS-1:0];
         r.overflowed = ovf_seen;
         expected_lengths.insert(expected_lengths.size(), r);
         tail_total = 0;
         ovf_seen   = 1'b0;
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on result %0d: %s got %0d, expected %0d",
               $time, lengths_checked, what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_value(logic [VALUE_W-1:0] v, logic last_flag);
      set_value_type item;
      item.value = v;
      item.last  = last_flag;
      pending_values.insert(pending_values.size(), item);
      queued_values++;
      if (last_flag) queued_sets++;
   endtask

   // Strictly rising values that spread over the whole range, with random jitter, used for
   // the set that fills the tail memory.
   function automatic logic [VALUE_W-1:0] rising_value(int idx);
      longint v;
      v = -64'sd2147483648 + longint'(idx) * 64'sd4000000 + longint'($urandom_range(0, 3999999));
      return v[VALUE_W-1:0];
   endfunction

   // One random set. Its shape is picked per set: fully random values, a narrow band that
   // makes equal values common, slow climbs with repeats, or a noisy climb.
   task automatic queue_random_set();
      int n;
      int shape;
      int base;
      int v;
      n     = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(17, 60);
      shape = $urandom_range(0, 3);
      base  = $urandom;
      for (int i = 0; i < n; i++) begin
         case (shape)
            0: v = $urandom;
            1: v = int'($urandom_range(0, 6)) - 3;
            2: v = base + i * int'($urandom_range(0, 5));
            default: begin
               if ($urandom_range(0, 3) == 0) v = $urandom;
               else v = base + i * 1000 - int'($urandom_range(0, 2000));
            end
         endcase
         queue_value(v, i == n - 1);
      end
   endtask

   // Mostly back to back, sometimes a short pause, rarely a long one.
   function automatic int pick_pause(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Driver: a value moves on every edge where valid and ready are both high. The tracker
   // sees it at that same edge, long before the block can answer.
   always @(posedge clock) begin
      set_value_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_value(req_tdata, req_tlast);
            accepted_values++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_pause > 0) begin
               send_pause--;
               req_tvalid <= 1'b0;
            end else if (pending_values.size() > 0) begin
               item = pending_values.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= item.value;
               req_tlast  <= item.last;
               if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
               send_pause = pick_pause(send_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result against the oldest expectation and sets ready for the next
   // edge. After a fixed number of results it holds off for a long stretch while the driver
   // keeps offering values, so the output register fills and the block stops taking input.
   always @(posedge clock) begin
      set_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_lengths.size() == 0) begin
               report_mismatch("unexpected transfer, lis_length", rsp_tdata[LEN_BITS-1:0], 0);
            end else begin
               want = expected_lengths.pop_front();
               if (rsp_tdata[LEN_BITS-1:0] !== want.lis_length)
                  report_mismatch("lis_length", rsp_tdata[LEN_BITS-1:0], want.lis_length);
               if (rsp_tdata[LEN_BITS] !== want.overflowed)
                  report_mismatch("overflowed", rsp_tdata[LEN_BITS], want.overflowed);
               if (rsp_tdata[RSP_DATA_BITS-1:LEN_BITS+1] !== '0)
                  report_mismatch("padding", rsp_tdata[RSP_DATA_BITS-1:LEN_BITS+1], 0);
               if (want.overflowed) overflow_sets++;
            end
            lengths_checked++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && lengths_checked >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
            stall_left = pick_pause(recv_calm);
            rsp_tready <= (stall_left == 0);
         end
      end
   end

   // Watchdog: counts edges with no transfer on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("lis_length_patience regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int random_goal;
      // Single-value sets at both ends of the range.
      queue_value(32'h8000_0000, 1'b1);
      queue_value(32'h7FFF_FFFF, 1'b1);
      // Repeated equal values never extend the run.
      queue_value(32'd5, 1'b0);
      queue_value(32'd5, 1'b0);
      queue_value(32'd5, 1'b1);
      // A climb across the sign boundary from the minimum to the maximum.
      queue_value(32'h8000_0000, 1'b0);
      queue_value(32'hFFFF_FFFF, 1'b0);
      queue_value(32'h0000_0000, 1'b0);
      queue_value(32'h0000_0001, 1'b0);
      queue_value(32'h7FFF_FFFF, 1'b1);
      // A strict fall.
      queue_value(32'h7FFF_FFFF, 1'b0);
      queue_value(32'h0000_0000, 1'b0);
      queue_value(32'h8000_0000, 1'b1);
      // Mixed order with alternating bit patterns, and a replacement by an equal value.
      queue_value(32'hAAAA_AAAA, 1'b0);
      queue_value(32'h5555_5555, 1'b0);
      queue_value(32'd3, 1'b0);
      queue_value(32'd1, 1'b0);
      queue_value(32'd4, 1'b0);
      queue_value(32'd1, 1'b0);
      queue_value(32'd5, 1'b0);
      queue_value(32'd2, 1'b0);
      queue_value(32'd2, 1'b0);
      queue_value(32'd6, 1'b1);

      // Fill every tail, then one append is refused, a replacement follows, and the last
      // value tries to append again.
      for (int i = 0; i < CAPACITY; i++) queue_value(rising_value(i), 1'b0);
      queue_value(32'h7FFF_FFFF, 1'b0);
      queue_value(32'h8000_0000, 1'b0);
      queue_value(32'h7FFF_FFFF, 1'b1);
      // The next set must start clean.
      queue_value(32'd42, 1'b1);

      random_goal = queued_values + RANDOM_ITEMS;
      while (queued_values < random_goal) queue_random_set();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (accepted_values != queued_values || expected_lengths.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d values in %0d sets and checked %0d lengths, %0d of them overflowed.",
               accepted_values, queued_sets, lengths_checked, overflow_sets);
      $display("The long receiver hold-off %0s, and %0d mismatches were found.",
               hold_done ? "took place" : "did not take place", mismatch_count);
      if (mismatch_count == 0) begin
         $display("lis_length_patience regression: pass");
      end else begin
         $display("lis_length_patience regression: fail");
      end
      $finish;
   end

endmodule
